// ===== rtl/core/fts_pkg.sv =====
// ----------------------------------------------------------------------------
// fts_pkg: shared types and constants of the footnote tag stripper
// Character codes recognized in the markup stream and the result beat type.
// ----------------------------------------------------------------------------
package fts_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CHAR_LT   = 8'h3C;  // '<'
    localparam logic [BYTE_W-1:0] CHAR_GT   = 8'h3E;  // '>'
    localparam logic [BYTE_W-1:0] CHAR_R    = 8'h52;  // 'R'
    localparam logic [BYTE_W-1:0] CHAR_F_UC = 8'h46;  // 'F'
    localparam logic [BYTE_W-1:0] CHAR_F_LC = 8'h66;  // 'f'
    localparam logic [BYTE_W-1:0] CHAR_NUL  = 8'h00;

    // one result beat
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              done;
        logic              last;
    } fts_beat_t;

endpackage

// ===== rtl/core/footnote_tag_stripper.sv =====
// ----------------------------------------------------------------------------
// footnote_tag_stripper: removes footnote sections from a markup byte stream
// Byte-serial filter with a tag buffer in RAM and a small replay sequencer.
// ----------------------------------------------------------------------------
// Usage: one text byte per request on the s_ side, one output byte per
// request on the m_ side. A '>' that closes a kept tag replays '<', the
// stored tag bytes and '>'; the tag bytes are read from the tag RAM's
// single read port one per cycle while the output is not stalled. A byte
// with s_tlast set is followed by a zero terminator beat. Input is
// held off while a replay or terminator is in progress and while the output
// register is full and not being taken. Tag bytes beyond TAG_CAPACITY are
// dropped. keep_footnotes (cfg_wr_en/cfg_wr_data) passes all bytes through;
// write it only while the block is idle.
module footnote_tag_stripper #(
    parameter int unsigned TAG_CAPACITY = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,   // keep_footnotes
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [7:0] text_byte
    input  logic       s_tlast,       // end_of_text
    // output stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // [7:0] out_byte
    output logic       m_tuser,       // text_done
    output logic       m_tlast        // last_of_run
);

    localparam int unsigned ADDR_W = (TAG_CAPACITY > 1) ? $clog2(TAG_CAPACITY) : 1;
    localparam int unsigned LEN_W  = $clog2(TAG_CAPACITY + 1);
    localparam int unsigned BW     = fts_pkg::BYTE_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BODY  = 3'd1;
    localparam logic [2:0] S_CLOSE = 3'd2;
    localparam logic [2:0] S_TERM  = 3'd3;

    logic [2:0]        state_reg, state_next;
    logic              keep_reg;
    logic              in_tag_reg, in_tag_next;
    logic              hiding_reg, hiding_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [BW-1:0]     first0_reg, first0_next;
    logic [BW-1:0]     first1_reg, first1_next;
    logic              eot_reg, eot_next;

    logic              out_valid_reg;
    fts_pkg::fts_beat_t out_beat_reg;
    fts_pkg::fts_beat_t beat;
    logic              ld_beat;
    logic              ld_ok;
    logic              fire;

    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BW-1:0]     ram_rdata;
    logic [LEN_W-1:0]  idx_inc;

    assign ld_ok    = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && ld_ok;
    assign fire     = s_tvalid && s_tready;
    assign idx_inc  = LEN_W'(idx_reg) + LEN_W'(1);

    fts_ram #(
        .WIDTH (BW),
        .DEPTH (TAG_CAPACITY)
    ) u_tag_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (len_reg[ADDR_W-1:0]),
        .wr_data (s_tdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next  = state_reg;
        in_tag_next = in_tag_reg;
        hiding_next = hiding_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        first0_next = first0_reg;
        first1_next = first1_reg;
        eot_next    = eot_reg;
        ld_beat     = 1'b0;
        beat        = '{data: fts_pkg::CHAR_NUL, done: 1'b0, last: 1'b0};
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = '0;

        case (state_reg)
            S_IDLE: begin
                if (fire) begin
                    eot_next   = s_tlast;
                    state_next = s_tlast ? S_TERM : S_IDLE;
                    if (keep_reg) begin
                        ld_beat = 1'b1;
                        beat    = '{data: s_tdata, done: 1'b0, last: !s_tlast};
                    end else if (s_tdata == fts_pkg::CHAR_LT) begin
                        in_tag_next = 1'b1;
                        len_next    = '0;
                    end else if (s_tdata == fts_pkg::CHAR_GT) begin
                        in_tag_next = 1'b0;
                        if (len_reg != '0 && first0_reg == fts_pkg::CHAR_R) begin
                            // footnote tag: only the second byte matters
                            if (len_reg >= LEN_W'(2)) begin
                                if (first1_reg == fts_pkg::CHAR_F_UC) begin
                                    hiding_next = 1'b1;
                                end else if (first1_reg == fts_pkg::CHAR_F_LC) begin
                                    hiding_next = 1'b0;
                                end
                            end
                        end else if (!hiding_reg) begin
                            ld_beat  = 1'b1;
                            beat     = '{data: fts_pkg::CHAR_LT, done: 1'b0, last: 1'b0};
                            idx_next = '0;
                            if (len_reg == '0) begin
                                state_next = S_CLOSE;
                            end else begin
                                ram_re     = 1'b1;
                                state_next = S_BODY;
                            end
                        end
                    end else if (in_tag_reg) begin
                        if (len_reg < LEN_W'(TAG_CAPACITY)) begin
                            ram_we = 1'b1;
                            if (len_reg == '0) begin
                                first0_next = s_tdata;
                            end
                            if (len_reg == LEN_W'(1)) begin
                                first1_next = s_tdata;
                            end
                            len_next = len_reg + LEN_W'(1);
                        end
                    end else if (!hiding_reg) begin
                        ld_beat = 1'b1;
                        beat    = '{data: s_tdata, done: 1'b0, last: !s_tlast};
                    end
                end
            end
            S_BODY: begin
                // read data holds while the output stalls
                if (ld_ok) begin
                    ld_beat = 1'b1;
                    beat    = '{data: ram_rdata, done: 1'b0, last: 1'b0};
                    if (idx_inc == len_reg) begin
                        state_next = S_CLOSE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_inc[ADDR_W-1:0];
                        idx_next  = idx_inc[ADDR_W-1:0];
                    end
                end
            end
            S_CLOSE: begin
                if (ld_ok) begin
                    ld_beat    = 1'b1;
                    beat       = '{data: fts_pkg::CHAR_GT, done: 1'b0, last: !eot_reg};
                    state_next = eot_reg ? S_TERM : S_IDLE;
                end
            end
            S_TERM: begin
                if (ld_ok) begin
                    ld_beat     = 1'b1;
                    beat        = '{data: fts_pkg::CHAR_NUL, done: 1'b1, last: 1'b1};
                    in_tag_next = 1'b0;
                    hiding_next = 1'b0;
                    len_next    = '0;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            keep_reg      <= 1'b0;
            in_tag_reg    <= 1'b0;
            hiding_reg    <= 1'b0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            in_tag_reg <= in_tag_next;
            hiding_reg <= hiding_next;
            len_reg    <= len_next;
            if (cfg_wr_en) begin
                keep_reg <= cfg_wr_data;
            end
            if (ld_beat) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        first0_reg <= first0_next;
        first1_reg <= first1_next;
        eot_reg    <= eot_next;
        if (ld_beat) begin
            out_beat_reg <= beat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_beat_reg.data;
    assign m_tuser  = out_beat_reg.done;
    assign m_tlast  = out_beat_reg.last;

`ifndef NO_ASSERTIONS
    // terminator always ends the run
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tuser || m_tlast))
        else $error("terminator without last_of_run");

    // end of text always leads to a terminator, so input is held off next cycle
    a_eot_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && s_tlast) |=> !s_tready)
        else $error("input accepted before terminator");

    // tag length never exceeds the buffer
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(TAG_CAPACITY))
        else $error("tag length overflow");

    // replay index stays inside the stored tag
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BODY) |-> (LEN_W'(idx_reg) < len_reg))
        else $error("replay index beyond tag length");
`endif

endmodule

// ===== rtl/core/fts_ram.sv =====
// ----------------------------------------------------------------------------
// fts_ram: generic single-write, single-read RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module fts_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for footnote_tag_stripper
// Drives marked-up text byte by byte, predicts the stripped output stream
// with a local model of the tag/hide logic and compares every output beat.
// Sender and receiver idle at random; keep_footnotes is toggled between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TAG_CAP  = 32;
    localparam int SETTLE   = 48;      // longest replay plus terminator, with margin
    localparam int HOLD_OFF = 300;

    typedef struct {
        logic [7:0] chr;
        logic       eot;
    } text_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    text_item_t         text_q[$];
    fts_pkg::fts_beat_t stripped_q[$];
    text_item_t         cur_item;

    int tx_idle_pct = 28;
    int rx_idle_pct = 74;
    bit rx_hold     = 1'b0;
    int mismatches  = 0;

    // local copy of the filter state
    logic       keep_mode = 1'b0;
    logic       in_tag    = 1'b0;
    logic       hiding    = 1'b0;
    logic [5:0] tag_len   = '0;
    logic [7:0] tag_buf [TAG_CAP];

    footnote_tag_stripper #(.TAG_CAPACITY(TAG_CAP)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // expected output of one accepted text byte
    function automatic void strip_byte(input logic [7:0] b, input logic eot);
        logic [7:0]         run_bytes[$];
        int                 n;
        fts_pkg::fts_beat_t nb;
        if (keep_mode) begin
            run_bytes = {run_bytes, b};
        end else if (b == fts_pkg::CHAR_LT) begin
            in_tag  = 1'b1;
            tag_len = '0;
        end else if (b == fts_pkg::CHAR_GT) begin
            in_tag = 1'b0;
            if (tag_len >= 1 && tag_buf[0] == fts_pkg::CHAR_R) begin
                if (tag_len >= 2) begin
                    if (tag_buf[1] == fts_pkg::CHAR_F_UC)
                        hiding = 1'b1;
                    else if (tag_buf[1] == fts_pkg::CHAR_F_LC)
                        hiding = 1'b0;
                end
            end else if (!hiding) begin
                run_bytes = {run_bytes, fts_pkg::CHAR_LT};
                for (int i = 0; i < tag_len; i++)
                    run_bytes = {run_bytes, tag_buf[i]};
                run_bytes = {run_bytes, fts_pkg::CHAR_GT};
            end
        end else if (in_tag) begin
            if (tag_len < TAG_CAP) begin
                tag_buf[tag_len] = b;
                tag_len = tag_len + 6'd1;
            end
        end else if (!hiding) begin
            run_bytes = {run_bytes, b};
        end

        n = run_bytes.size();
        for (int i = 0; i < n; i++) begin
            nb.data    = run_bytes[i];
            nb.done    = 1'b0;
            nb.last    = (i == n - 1) && !eot;
            stripped_q = {stripped_q, nb};
        end
        if (eot) begin
            nb.data    = fts_pkg::CHAR_NUL;
            nb.done    = 1'b1;
            nb.last    = 1'b1;
            stripped_q = {stripped_q, nb};
            in_tag  = 1'b0;
            hiding  = 1'b0;
            tag_len = '0;
        end
    endfunction

    // sender: one request per accepted byte, prediction at acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                strip_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (text_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    cur_item = text_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_item.chr;
                    s_tlast  <= cur_item.eot;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        fts_pkg::fts_beat_t exp_beat;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (stripped_q.size() == 0) begin
                    $error("unexpected output beat: out_byte %0h text_done %0b last_of_run %0b",
                           m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end else begin
                    exp_beat = stripped_q.pop_front();
                    if (m_tdata !== exp_beat.data) begin
                        $error("out_byte: expected %0h, got %0h", exp_beat.data, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser !== exp_beat.done) begin
                        $error("text_done: expected %0b, got %0b", exp_beat.done, m_tuser);
                        mismatches++;
                    end
                    if (m_tlast !== exp_beat.last) begin
                        $error("last_of_run: expected %0b, got %0b", exp_beat.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic push_item(input logic [7:0] b, input logic eot);
        text_item_t it;
        it.chr = b;
        it.eot = eot;
        text_q = {text_q, it};
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i], 1'b0);
    endtask

    // any nonzero byte except the tag delimiters
    function automatic logic [7:0] any_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        if (c == fts_pkg::CHAR_LT || c == fts_pkg::CHAR_GT)
            c = c ^ 8'h40;
        return c;
    endfunction

    task automatic add_segment(input int kind);
        int n;
        if (kind < 35) begin
            n = $urandom_range(1, 6);
            repeat (n) push_item(any_char(), 1'b0);
        end else if (kind < 55) begin
            push_item(fts_pkg::CHAR_LT, 1'b0);
            n = $urandom_range(0, 6);
            repeat (n) push_item(any_char(), 1'b0);
            push_item(fts_pkg::CHAR_GT, 1'b0);
        end else if (kind < 75) begin
            // footnote open or close marker
            push_item(fts_pkg::CHAR_LT, 1'b0);
            push_item(fts_pkg::CHAR_R, 1'b0);
            push_item(kind < 65 ? fts_pkg::CHAR_F_UC : fts_pkg::CHAR_F_LC, 1'b0);
            n = $urandom_range(0, 3);
            repeat (n) push_item(any_char(), 1'b0);
            push_item(fts_pkg::CHAR_GT, 1'b0);
        end else if (kind < 80) begin
            // bare 'R' tag or 'R' with one random second byte
            push_item(fts_pkg::CHAR_LT, 1'b0);
            push_item(fts_pkg::CHAR_R, 1'b0);
            if ($urandom_range(1))
                push_item(any_char(), 1'b0);
            push_item(fts_pkg::CHAR_GT, 1'b0);
        end else if (kind < 85) begin
            // overflows the tag buffer
            push_item(fts_pkg::CHAR_LT, 1'b0);
            n = $urandom_range(TAG_CAP + 1, TAG_CAP + 4);
            repeat (n) push_item(any_char(), 1'b0);
            push_item(fts_pkg::CHAR_GT, 1'b0);
        end else if (kind < 90) begin
            push_item(fts_pkg::CHAR_LT, 1'b0);
            n = $urandom_range(1, 3);
            repeat (n) push_item(any_char(), 1'b0);
            push_item(fts_pkg::CHAR_LT, 1'b0);
            n = $urandom_range(0, 3);
            repeat (n) push_item(any_char(), 1'b0);
            push_item(fts_pkg::CHAR_GT, 1'b0);
        end else if (kind < 95) begin
            push_item(fts_pkg::CHAR_GT, 1'b0);
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) push_item(8'($urandom_range(1, 255)), 1'b0);
        end
    endtask

    // whole texts of random structure, each closed by an end-of-text byte
    task automatic add_texts(input int total);
        int added;
        int start;
        int tlen;
        added = 0;
        while (added < total) begin
            start = text_q.size();
            tlen  = $urandom_range(6, 40);
            while (text_q.size() - start < tlen)
                add_segment(int'($urandom_range(99)));
            text_q[text_q.size() - 1].eot = 1'b1;
            added += text_q.size() - start;
        end
    endtask

    // waits until all queued text is sent and every expected beat is out, then the block settles
    task automatic drain_and_settle();
        @(negedge aclk);
        while (text_q.size() != 0 || s_tvalid || stripped_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_keep(input logic v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        keep_mode = v;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        write_keep(1'b0);

        // stray close on an empty store, byte extremes, footnote markers,
        // hidden tag, nested open, repeated stray close, zero byte at the end
        push_str(">");
        push_item(8'h01, 1'b0);
        push_item(8'hFF, 1'b0);
        push_str("<R><RF>x<i><Rf><a<b>>");
        push_item(fts_pkg::CHAR_NUL, 1'b1);
        drain_and_settle();

        // hiding set, then keep mode must leave tag state alone
        push_str("<RF>");
        drain_and_settle();
        write_keep(1'b1);
        push_str("<ab>");
        drain_and_settle();
        write_keep(1'b0);
        push_item("z", 1'b1);
        drain_and_settle();

        // random texts, receiver stalls hard at first
        tx_idle_pct = 28;
        rx_idle_pct = 74;
        add_segment(82);
        add_texts(100);
        rx_hold = 1'b1;
        repeat (HOLD_OFF) @(posedge aclk);
        rx_hold = 1'b0;
        drain_and_settle();

        write_keep(1'b1);
        tx_idle_pct = 74;
        rx_idle_pct = 28;
        add_texts(50);
        drain_and_settle();

        write_keep(1'b0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        add_texts(120);
        drain_and_settle();

        if (stripped_q.size() != 0) begin
            $error("%0d expected output beats never arrived", stripped_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
